// ----- design/dtgi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drift-time grid interpolator package
// Shared constants, codes, types and state encoding.
// ----------------------------------------------------------------------------
package dtgi_pkg;
   localparam int MAX_POINTS = 64;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W = ADDR_W + 1;
   localparam int ENTRY_W = 50;
   localparam int DIV_W = 40;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_QTIME = 2'd2;
   localparam logic [1:0] OP_QRAD = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FEW = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE, S_LSCAN, S_LWAIT, S_LCHK, S_SHRD, S_SHWAIT, S_SHWR, S_LWR,
      S_QSCAN, S_QWAIT, S_QCHK, S_QRDA, S_QWAITA, S_QCAPA,
      S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_MUL3, S_DIV3, S_FIN, S_OUT
   } state_type;

   typedef struct packed {
      logic signed [17:0] t;
      logic [15:0] r;
      logic [15:0] res;
   } entry_type;

   typedef struct packed {
      logic [1:0] status;
      logic [15:0] radius;
      logic signed [24:0] slope;
      logic [15:0] resolution;
      logic signed [17:0] time_v;
   } result_type;
endpackage
`default_nettype wire

// ----- design/drift_time_grid_interpolator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drift-time grid interpolator
// Time-sorted grid of (time, radius, resolution) points held in one RAM.
// A load scans for the insert place and shifts the tail up one entry at a
// time, through a read, a wait and a write state per shifted entry. A query
// scans the grid through a scan, a wait and a check state per entry, then
// runs up to three serial divides. Both scans go through the single read
// port. One word is handled at a time; the result register lets the next
// word in while the previous result waits.
// ----------------------------------------------------------------------------
module drift_time_grid_interpolator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // operation[1:0], drift_time[19:2], radius_in[35:20], resolution_in[51:36]
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], radius_out[17:2], slope_out[42:18], resolution_out[58:43],
   // time_out[76:59]
   output logic [79:0]      rsp_tdata
);
   import dtgi_pkg::*;

   state_type st_ff, st_in;
   logic [15:0] half_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [1:0] op_ff, op_in;
   logic signed [17:0] t_ff, t_in;
   logic [15:0] r_ff, r_in, res_ff, res_in;
   entry_type a_ff, a_in, b_ff, b_in;
   logic signed [39:0] prod_ff, prod_in;
   logic signed [39:0] den_ff, den_in;
   logic signed [39:0] q1_ff, q1_in, q2_ff, q2_in;
   logic div_start;
   logic div_done;
   logic signed [39:0] div_q;
   result_type out_ff, out_in;
   logic ov_ff, ov_in;

   logic ram_we;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   entry_type ram_wd, ram_rd;

   logic signed [18:0] d_tq, d_tab;
   logic signed [16:0] d_rq, d_rab, d_sab;

   dtgi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   dtgi_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(prod_ff),
      .divisor(den_ff), .done(div_done), .quotient(div_q)
   );

   assign d_tq = 19'(t_ff) - 19'(a_ff.t);
   assign d_tab = 19'(b_ff.t) - 19'(a_ff.t);
   assign d_rq = $signed({1'b0, r_ff}) - $signed({1'b0, a_ff.r});
   assign d_rab = $signed({1'b0, b_ff.r}) - $signed({1'b0, a_ff.r});
   assign d_sab = $signed({1'b0, b_ff.res}) - $signed({1'b0, a_ff.res});

   logic hit;
   logic signed [40:0] rad_v;
   logic signed [39:0] tq;

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      op_in = op_ff;
      t_in = t_ff;
      r_in = r_ff;
      res_in = res_ff;
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      den_in = den_ff;
      q1_in = q1_ff;
      q2_in = q2_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      div_start = 1'b0;
      ram_we = 1'b0;
      ram_wa = '0;
      ram_wd = '0;
      ram_ra = k_ff[ADDR_W-1:0];
      req_tready = 1'b0;
      hit = 1'b0;
      rad_v = '0;
      tq = '0;
      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      case (st_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = req_tdata[1:0];
               t_in = req_tdata[19:2];
               r_in = req_tdata[35:20];
               res_in = req_tdata[51:36];
               k_in = '0;
               out_in = '0;
               case (req_tdata[1:0])
                  OP_CLEAR: begin
                     cnt_in = '0;
                     st_in = S_OUT;
                  end
                  OP_LOAD: begin
                     if (cnt_ff >= CNT_W'(MAX_POINTS)) begin
                        out_in.status = ST_FULL;
                        st_in = S_OUT;
                     end else begin
                        st_in = S_LSCAN;
                     end
                  end
                  default: begin
                     if (cnt_ff < CNT_W'(2)) begin
                        out_in.status = ST_FEW;
                        st_in = S_OUT;
                     end else begin
                        st_in = S_QSCAN;
                     end
                  end
               endcase
            end
         end
         S_LSCAN: begin
            if (k_ff == cnt_ff) begin
               k_in = cnt_ff;
               q1_in = 40'(cnt_ff);
               st_in = S_SHRD;
            end else begin
               st_in = S_LWAIT;
            end
         end
         S_LWAIT: st_in = S_LCHK;
         S_LCHK: begin
            if (ram_rd.t <= t_ff) begin
               k_in = k_ff + 1'b1;
               st_in = S_LSCAN;
            end else begin
               a_in.t = '0;
               q1_in = 40'(k_ff);
               k_in = cnt_ff;
               st_in = S_SHRD;
            end
         end
         S_SHRD: begin
            if (k_ff == CNT_W'(q1_ff) || k_ff == cnt_ff && k_ff == '0) begin
               st_in = S_LWR;
            end else begin
               ram_ra = ADDR_W'(k_ff - 1'b1);
               st_in = S_SHWAIT;
            end
            if (k_ff == cnt_ff && CNT_W'(q1_ff) == cnt_ff) begin
               st_in = S_LWR;
            end
         end
         S_SHWAIT: begin
            ram_ra = ADDR_W'(k_ff - 1'b1);
            st_in = S_SHWR;
         end
         S_SHWR: begin
            ram_we = 1'b1;
            ram_wa = k_ff[ADDR_W-1:0];
            ram_wd = ram_rd;
            k_in = k_ff - 1'b1;
            st_in = S_SHRD;
         end
         S_LWR: begin
            ram_we = 1'b1;
            ram_wa = k_ff[ADDR_W-1:0];
            ram_wd.t = t_ff;
            ram_wd.r = r_ff;
            ram_wd.res = res_ff;
            cnt_in = cnt_ff + 1'b1;
            st_in = S_OUT;
         end
         S_QSCAN: begin
            if (k_ff == cnt_ff) begin
               k_in = cnt_ff - 1'b1;
               q1_in = 40'sd1;
               st_in = S_QRDA;
            end else begin
               st_in = S_QWAIT;
            end
         end
         S_QWAIT: st_in = S_QCHK;
         S_QCHK: begin
            hit = (op_ff == OP_QTIME) ? !(ram_rd.t < t_ff) : !(ram_rd.r < r_ff);
            if (hit) begin
               b_in = ram_rd;
               if (k_ff == '0) begin
                  q1_in = 40'sd1;
                  st_in = S_QCAPA;
                  a_in = ram_rd;
               end else begin
                  q1_in = 40'sd0;
                  k_in = k_ff - 1'b1;
                  st_in = S_QRDA;
               end
            end else begin
               k_in = k_ff + 1'b1;
               st_in = S_QSCAN;
            end
         end
         S_QRDA: st_in = S_QWAITA;
         S_QWAITA: begin
            a_in = ram_rd;
            st_in = S_QCAPA;
         end
         S_QCAPA: begin
            if (q1_ff != 40'sd0) begin
               if (op_ff == OP_QTIME) begin
                  out_in.status = ST_RANGE;
                  out_in.resolution = a_ff.res;
                  rad_v = 41'(a_ff.r);
                  if (rad_v > 41'(half_ff)) begin
                     out_in.radius = half_ff;
                  end else begin
                     out_in.radius = a_ff.r;
                  end
               end else begin
                  out_in.time_v = a_ff.t;
               end
               st_in = S_OUT;
            end else begin
               st_in = S_MUL1;
            end
         end
         S_MUL1: begin
            if (op_ff == OP_QTIME) begin
               prod_in = 40'(d_tq * d_rab);
               den_in = 40'(d_tab);
            end else begin
               prod_in = 40'(d_rq * d_tab);
               den_in = 40'(d_rab);
            end
            if (den_in == '0) begin
               q1_in = '0;
               st_in = S_MUL2;
            end else begin
               st_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (!div_done && q1_ff != 40'sd2) begin
               div_start = 1'b1;
               q1_in = 40'sd2;
            end else if (div_done) begin
               q1_in = div_q;
               st_in = S_MUL2;
            end
         end
         S_MUL2: begin
            if (op_ff == OP_QRAD) begin
               if (den_ff == '0) begin
                  tq = 40'(b_ff.t);
               end else begin
                  tq = 40'(a_ff.t) + q1_ff;
               end
               out_in.time_v = 18'(tq);
               st_in = S_OUT;
            end else begin
               prod_in = 40'(d_tq * d_sab);
               q2_in = '0;
               st_in = (den_ff == '0) ? S_MUL3 : S_DIV2;
            end
         end
         S_DIV2: begin
            if (!div_done && q2_ff != 40'sd2) begin
               div_start = 1'b1;
               q2_in = 40'sd2;
            end else if (div_done) begin
               q2_in = div_q;
               st_in = S_MUL3;
            end
         end
         S_MUL3: begin
            prod_in = 40'(d_rab) <<< 8;
            out_in.slope = '0;
            out_in.time_v = 18'sd3;
            st_in = (den_ff == '0) ? S_FIN : S_DIV3;
         end
         S_DIV3: begin
            if (!div_done && out_ff.time_v != 18'sd2) begin
               div_start = 1'b1;
               out_in.time_v = 18'sd2;
            end else if (div_done) begin
               out_in.slope = 25'(div_q);
               st_in = S_FIN;
            end
         end
         S_FIN: begin
            out_in.time_v = '0;
            if (den_ff == '0) begin
               rad_v = 41'(b_ff.r);
               out_in.resolution = b_ff.res;
            end else begin
               rad_v = 41'(a_ff.r) + 41'(q1_ff);
               out_in.resolution = 16'(40'(a_ff.res) + q2_ff);
            end
            out_in.status = ST_OK;
            if (rad_v < 0) begin
               out_in.radius = '0;
               out_in.status = ST_RANGE;
            end else if (rad_v > 41'(half_ff)) begin
               out_in.radius = half_ff;
               out_in.status = ST_RANGE;
            end else begin
               out_in.radius = 16'(rad_v);
            end
            st_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               st_in = S_IDLE;
            end else begin
               out_in = out_ff;
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_OUT && ov_ff && !rsp_tready) begin
         out_in = out_ff;
      end
   end

   logic [1:0] res_hold;
   assign res_hold = '0;

   result_type rsp_ff, rsp_in;
   always_comb begin
      rsp_in = rsp_ff;
      if (st_ff == S_OUT && (!ov_ff || rsp_tready)) begin
         rsp_in = out_ff;
         rsp_in.status = out_ff.status | res_hold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         cnt_ff <= '0;
         half_ff <= 16'hFFFF;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         ov_ff <= ov_in;
         if (csr_we) begin
            half_ff <= csr_wdata;
         end
      end
      k_ff <= k_in;
      op_ff <= op_in;
      t_ff <= t_in;
      r_ff <= r_in;
      res_ff <= res_in;
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      den_ff <= den_in;
      q1_ff <= q1_in;
      q2_ff <= q2_in;
      out_ff <= out_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {3'b000, rsp_ff.time_v, rsp_ff.resolution, rsp_ff.slope,
                       rsp_ff.radius, rsp_ff.status};
endmodule
`default_nettype wire

// ----- design/dtgi_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dtgi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- design/dtgi_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module dtgi_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [dtgi_pkg::DIV_W-1:0]   dividend,
   input  wire logic signed [dtgi_pkg::DIV_W-1:0]   divisor,
   output logic                                     done,
   output logic signed [dtgi_pkg::DIV_W-1:0]        quotient
);
   import dtgi_pkg::*;

   logic [DIV_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [$clog2(DIV_W+1)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_W:0] trial;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = '0;
      if (start) begin
         num_in = dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
         den_in = divisor[DIV_W-1] ? DIV_W'(-divisor) : divisor;
         neg_in = dividend[DIV_W-1] ^ divisor[DIV_W-1];
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[DIV_W-1:0], num_ff[DIV_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(DIV_W+1))'(DIV_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -$signed(num_ff) : $signed(num_ff);
endmodule
`default_nettype wire
